// ----- rtl/dfiir_pkg.sv -----
`timescale 1ns / 1ps

package dfiir_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 16;
   localparam int PROD_W     = SAMPLE_W + COEF_W;
   localparam int NUM_REGS   = 7;
   localparam int NUM_FF     = 4;
   localparam int REG_IDX_W  = 3;
   localparam int ROUND_SHIFT = 14;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic [REG_IDX_W-1:0]       reg_idx_type;

   localparam reg_idx_type REG_COEF_B0 = 3'd0;
   localparam reg_idx_type REG_COEF_B1 = 3'd1;
   localparam reg_idx_type REG_COEF_B2 = 3'd2;
   localparam reg_idx_type REG_COEF_B3 = 3'd3;
   localparam reg_idx_type REG_COEF_A1 = 3'd4;
   localparam reg_idx_type REG_COEF_A2 = 3'd5;
   localparam reg_idx_type REG_COEF_A3 = 3'd6;

   localparam coef_type COEF_B0_RESET = 16'sd16384;

   localparam sample_type SAMPLE_MAX = 16'sh7fff;
   localparam sample_type SAMPLE_MIN = 16'sh8000;

endpackage

// ----- rtl/direct_form_one_iir_filter_unit.sv -----
`timescale 1ns / 1ps

// Direct-form-I IIR filter with one shared 16x16 multiplier.
// req_ channel: one beat carries req_sample_in (signed Q1.15). req_stall is
// high while a sample is being filtered, so one sample is in flight at once.
// rsp_ channel: one beat carries rsp_sample_out (signed Q1.15), rounded half
// up and saturated. The result sits in an output register; the next request
// is taken while it waits, and the filter holds its finished sum until the
// register frees up.
// The sample runs through the shared multiply-accumulate one tap at a time
// (2*HALF_TAPS-1 taps), then a step drains the product register and a step
// rounds and saturates. A new request is taken only once the last result
// has been committed to the output register. While the receiver stalls, the
// next sample runs on to the round step and holds there, and req_stall stays
// high until the output register frees up.
// csr_ port: write coefficient csr_index (b0..b3, a1..a3, Q2.14) whenever
// csr_write_enable is high; indexes past the list are dropped. Write only
// while idle.
// Reset: synchronous; clears both histories and the write index, loads
// b0 = 1.0 and all other coefficients to zero, and drops any pending result.
module direct_form_one_iir_filter_unit
   import dfiir_pkg::*;
#(
   parameter int HALF_TAPS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  sample_type  req_sample_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output sample_type  rsp_sample_out,
   input  logic        csr_write_enable,
   input  reg_idx_type csr_index,
   input  coef_type    csr_data
);

   localparam int IDX_W   = (HALF_TAPS > 2) ? $clog2(HALF_TAPS) : 1;
   localparam int BACK_W  = IDX_W + 2;
   localparam int STEPS   = 2 * HALF_TAPS - 1;
   localparam int STEP_W  = $clog2(STEPS);
   localparam int ACC_W   = PROD_W + 4;
   localparam int Q_W     = ACC_W - ROUND_SHIFT;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MAC   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_ROUND = 2'd3;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);
   localparam logic [STEP_W-1:0] STEP_H    = STEP_W'(HALF_TAPS);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(HALF_TAPS - 1);
   localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1 << (ROUND_SHIFT - 1));

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [IDX_W-1:0]  wi_ff;
   coef_type          coef_ff [NUM_REGS];
   sample_type        xhist_ff [HALF_TAPS];
   sample_type        yhist_ff [HALF_TAPS];
   prod_type          prod_ff;
   logic              prod_valid_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic              rsp_valid_ff;
   sample_type        rsp_sample_ff;

   logic              req_accept;
   logic              rsp_free;
   logic              is_ff_tap;
   logic [STEP_W-1:0] tap_k;
   logic [BACK_W-1:0] back_raw;
   logic [BACK_W-1:0] back_mod;
   logic [IDX_W-1:0]  back_idx;
   reg_idx_type       coef_idx;
   coef_type          coef_sel;
   sample_type        hist_sel;
   prod_type          prod_in;
   logic signed [ACC_W-1:0] acc_rnd;
   logic signed [Q_W-1:0]   q_val;
   sample_type        sat_val;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

   // tap select: feedforward taps first, then feedback taps 1..H-1
   always_comb begin
      is_ff_tap = (step_ff < STEP_H);
      tap_k     = is_ff_tap ? step_ff : (step_ff - STEP_H + STEP_W'(1));
      back_raw  = BACK_W'(wi_ff) + BACK_W'(HALF_TAPS) - BACK_W'(tap_k);
      back_mod  = (back_raw >= BACK_W'(HALF_TAPS)) ? (back_raw - BACK_W'(HALF_TAPS))
                                                    : back_raw;
      back_idx  = back_mod[IDX_W-1:0];
      coef_idx  = is_ff_tap ? REG_IDX_W'(step_ff)
                            : REG_IDX_W'(REG_IDX_W'(step_ff) + REG_IDX_W'(NUM_FF)
                                         - REG_IDX_W'(HALF_TAPS));
      coef_sel  = coef_ff[coef_idx];
      hist_sel  = is_ff_tap ? xhist_ff[back_idx] : yhist_ff[back_idx];
      prod_in   = coef_sel * hist_sel;
   end

   always_comb begin
      acc_rnd = acc_ff + ROUND_BIAS;
      q_val   = Q_W'(acc_rnd >>> ROUND_SHIFT);
      if (q_val > Q_W'(SAMPLE_MAX)) begin
         sat_val = SAMPLE_MAX;
      end else if (q_val < Q_W'(SAMPLE_MIN)) begin
         sat_val = SAMPLE_MIN;
      end else begin
         sat_val = SAMPLE_W'(q_val);
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_MAC;
               step_in  = '0;
            end
         end
         ST_MAC: begin
            if (step_ff == LAST_STEP) begin
               state_in = ST_DRAIN;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         wi_ff         <= '0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < NUM_REGS; i++) begin
            coef_ff[i] <= (i == int'(REG_COEF_B0)) ? COEF_B0_RESET : '0;
         end
         for (int i = 0; i < HALF_TAPS; i++) begin
            xhist_ff[i] <= '0;
            yhist_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         prod_valid_ff <= (state_ff == ST_MAC);

         if (csr_write_enable && (csr_index <= REG_COEF_A3)) begin
            coef_ff[csr_index] <= csr_data;
         end

         if (req_accept) begin
            xhist_ff[wi_ff] <= req_sample_in;
         end

         // commit: store result, advance write index, load response
         if ((state_ff == ST_ROUND) && rsp_free) begin
            yhist_ff[wi_ff] <= sat_val;
            wi_ff           <= (wi_ff == LAST_IDX) ? '0 : (wi_ff + IDX_W'(1));
            rsp_valid_ff    <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (req_accept) begin
         acc_ff <= '0;
      end else if (prod_valid_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      if ((state_ff == ST_ROUND) && rsp_free) begin
         rsp_sample_ff <= sat_val;
      end
   end

`ifndef SYNTHESIS
   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> ##(2*HALF_TAPS+1) (state_ff == ST_ROUND))
      else $error("round step not reached at fixed latency");

   a_commit: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_ROUND) && rsp_free) |=> (rsp_valid_ff && (state_ff == ST_IDLE)
                                                && (wi_ff != $past(wi_ff)
                                                    || HALF_TAPS == 1)))
      else $error("commit did not load response or advance write index");

   a_prod_window: assert property (@(posedge clock) disable iff (reset)
      prod_valid_ff |-> ((state_ff == ST_MAC) || (state_ff == ST_DRAIN)))
      else $error("product accumulated outside tap sweep");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(rsp_sample_ff) || !rsp_valid_ff)
      else $error("pending response overwritten");
`endif

endmodule
